// ----- sv/ffca_pkg.sv -----
// ffca_pkg: shared constants, payload structs and codes for the first-fit allocator.
// Used by first_fit_coalescing_allocator; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none
package ffca_pkg;

    localparam int HEAP_BYTES      = 262144;
    localparam int GRANULE_BYTES   = 8;
    localparam int GRANULES        = HEAP_BYTES / GRANULE_BYTES;
    localparam int GIDX_W          = $clog2(GRANULES);
    localparam int BYTE_W          = 19;
    localparam int ADDR_W          = 18;
    localparam int REQ_W           = 32;
    localparam int CNT_W           = 32;
    localparam int HEAP_SIZE_RESET = 32'h0002_F000;
    localparam int MIN_HEAP        = 64;
    localparam int HDR_BYTES       = 8;
    localparam int MIN_SPLIT       = 2 * HDR_BYTES;

    typedef logic [GIDX_W-1:0] gidx_t;
    typedef logic [BYTE_W-1:0] nbytes_t;

    typedef enum logic
    {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_DONE       = 2'd0,
        ST_ALLOC_FAIL = 2'd1,
        ST_REL_REJECT = 2'd2,
        ST_REL_NULL   = 2'd3
    } status_t;

    // block header: next free granule, block size in bytes
    typedef struct packed
    {
        gidx_t   nxt;
        nbytes_t size;
    } hdr_t;

    localparam int HDR_W = $bits(hdr_t);

    typedef struct packed
    {
        op_t               op;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] release_address;
    } in_item_t;

    typedef struct packed
    {
        status_t           status;
        logic [ADDR_W-1:0] address;
        nbytes_t           free_bytes;
        nbytes_t           min_free_bytes;
        logic [CNT_W-1:0]  alloc_count;
        logic [CNT_W-1:0]  free_count;
    } out_item_t;

endpackage
`default_nettype wire

// ----- sv/ffca_ram.sv -----
// ffca_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ----- sv/first_fit_coalescing_allocator.sv -----
// first_fit_coalescing_allocator: address-ordered first-fit heap allocator, top level.
// Depends on ffca_pkg and ffca_ram (header store and allocated marks).
`timescale 1ns / 1ps
`default_nettype none
// One item at a time: the block is not ready from acceptance until the result sits in the
// output register, and is ready for the next item in the cycle that the result appears
// there. After reset the allocated marks are cleared, one entry per cycle, and the block
// takes no item until all are cleared. The first allocate builds the free list, end marker
// then head. An allocate reads and checks each free block in turn until one fits and
// unlinks it; a split walks the list to the tail's place and merges the tail with its
// neighbours. An allocate fails on a zero or oversized request or one above the free
// bytes, or when the search reaches the end marker. A release checks the allocated mark,
// then walks and merges like a split; a null or misaligned one goes straight to the
// result, an unmarked one ends after the mark check. A result held by out_ready low keeps
// the block in its last state and stalls the next item. The header store has one read port
// with registered data, so each step of a list walk is a read and a check.
module first_fit_coalescing_allocator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire ffca_pkg::in_item_t             in_item,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output ffca_pkg::out_item_t                 out_item,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ffca_pkg::BYTE_W-1:0]    cfg_wr_data
);

    typedef enum logic [15:0]
    {
        S_CLEAR      = 16'h0001,
        S_IDLE       = 16'h0002,
        S_BUILD_END  = 16'h0004,
        S_BUILD_HEAD = 16'h0008,
        S_A_REQ      = 16'h0010,
        S_A_RD       = 16'h0020,
        S_A_CHK      = 16'h0040,
        S_A_UNLINK   = 16'h0080,
        S_PB_RD      = 16'h0100,
        S_PB_CHK     = 16'h0200,
        S_PB_CUR     = 16'h0400,
        S_PB_MRG     = 16'h0800,
        S_PB_IT      = 16'h1000,
        S_FIN        = 16'h2000,
        S_REL_CHK    = 16'h4000,
        S_RESP       = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // control state
    ffca_pkg::gidx_t               clr_cnt_reg;
    ffca_pkg::nbytes_t             heap_size_reg;
    logic                          list_ready_reg;
    ffca_pkg::gidx_t               list_head_reg;
    ffca_pkg::gidx_t               end_marker_reg;
    ffca_pkg::nbytes_t             bytes_free_reg;
    ffca_pkg::nbytes_t             lowest_free_reg;
    logic [ffca_pkg::CNT_W-1:0]    alloc_cnt_reg;
    logic [ffca_pkg::CNT_W-1:0]    free_cnt_reg;
    logic                          out_valid_reg;

    // working registers
    logic                          is_rel_reg;
    logic                          pre_fail_reg;
    ffca_pkg::nbytes_t             w_reg;
    ffca_pkg::gidx_t               blk_reg;
    ffca_pkg::gidx_t               blk_next_reg;
    ffca_pkg::nbytes_t             blk_size_reg;
    ffca_pkg::gidx_t               prev_reg;
    ffca_pkg::nbytes_t             prev_size_reg;
    logic                          prev_start_reg;
    ffca_pkg::gidx_t               b_reg;
    ffca_pkg::nbytes_t             b_size_reg;
    ffca_pkg::gidx_t               nxt_reg;
    ffca_pkg::hdr_t                nxt_hdr_reg;
    ffca_pkg::gidx_t               it_reg;
    ffca_pkg::nbytes_t             it_size_reg;
    logic                          at_start_reg;
    ffca_pkg::gidx_t               cur_reg;
    ffca_pkg::nbytes_t             cur_size_reg;
    logic                          left_reg;
    ffca_pkg::nbytes_t             fsize_reg;
    ffca_pkg::status_t             status_reg;
    logic [ffca_pkg::ADDR_W-1:0]   addr_reg;
    ffca_pkg::out_item_t           out_item_reg;

    // memories
    logic                          hdr_we;
    ffca_pkg::gidx_t               hdr_waddr;
    ffca_pkg::hdr_t                hdr_wdata;
    ffca_pkg::gidx_t               hdr_raddr;
    ffca_pkg::hdr_t                hdr_rd;
    logic                          mark_we;
    ffca_pkg::gidx_t               mark_waddr;
    logic                          mark_wdata;
    logic                          mark_rd;

    // input decode
    logic                          in_acc;
    logic [3:0]                    pad;
    logic [ffca_pkg::REQ_W:0]      padded;
    logic                          req_fail;
    logic [ffca_pkg::ADDR_W-1:0]   rel_a;
    ffca_pkg::gidx_t               rel_g;
    logic                          rel_null;
    logic                          rel_bad;

    // list build
    ffca_pkg::nbytes_t             eff_size;
    ffca_pkg::nbytes_t             end_off;
    ffca_pkg::gidx_t               build_end;

    // step arithmetic
    ffca_pkg::nbytes_t             rem;
    logic                          split;
    logic                          left;
    logic                          right;
    logic                          mrg;
    ffca_pkg::nbytes_t             mrg_size;
    ffca_pkg::gidx_t               mrg_next;
    ffca_pkg::nbytes_t             fin_free;
    logic                          resp_go;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign resp_go   = !out_valid_reg || out_ready;

    // header plus rounding: multiple of 8 gets the header alone
    assign pad      = (in_item.request_bytes[2:0] == 3'd0) ? 4'd8
                      : 4'd8 + 4'd8 - {1'b0, in_item.request_bytes[2:0]};
    assign padded   = {1'b0, in_item.request_bytes} + {{(ffca_pkg::REQ_W - 3){1'b0}}, pad};
    assign req_fail = (in_item.request_bytes == '0) ||
                      (padded[ffca_pkg::REQ_W:ffca_pkg::BYTE_W] != '0);

    assign rel_a    = in_item.release_address;
    assign rel_null = (rel_a == '0);
    assign rel_bad  = (rel_a[2:0] != 3'd0) || (rel_a[ffca_pkg::ADDR_W-1:3] == '0);
    assign rel_g    = rel_a[ffca_pkg::ADDR_W-1:3] - ffca_pkg::gidx_t'(1);

    always_comb
    begin
        if (heap_size_reg < ffca_pkg::nbytes_t'(ffca_pkg::MIN_HEAP))
        begin
            eff_size = ffca_pkg::nbytes_t'(ffca_pkg::MIN_HEAP);
        end
        else if (heap_size_reg > ffca_pkg::nbytes_t'(ffca_pkg::HEAP_BYTES))
        begin
            eff_size = ffca_pkg::nbytes_t'(ffca_pkg::HEAP_BYTES);
        end
        else
        begin
            eff_size = heap_size_reg;
        end
    end

    assign end_off   = (eff_size - ffca_pkg::nbytes_t'(ffca_pkg::HDR_BYTES)) &
                       ~ffca_pkg::nbytes_t'(ffca_pkg::HDR_BYTES - 1);
    assign build_end = end_off[ffca_pkg::GIDX_W+2:3];

    assign rem   = blk_size_reg - w_reg;
    assign split = rem > ffca_pkg::nbytes_t'(ffca_pkg::MIN_SPLIT);

    // left neighbour ends where the returned block starts
    assign left = !at_start_reg &&
                  (({1'b0, it_reg} + {1'b0, it_size_reg[ffca_pkg::GIDX_W+2:3]}) ==
                   {1'b0, b_reg});
    assign right = (({1'b0, cur_reg} + {1'b0, cur_size_reg[ffca_pkg::GIDX_W+2:3]}) ==
                    {1'b0, nxt_reg});
    assign mrg      = right && (nxt_reg != end_marker_reg);
    assign mrg_size = mrg ? cur_size_reg + nxt_hdr_reg.size : cur_size_reg;
    assign mrg_next = mrg ? nxt_hdr_reg.nxt : nxt_reg;
    assign fin_free = bytes_free_reg - fsize_reg;

    // memory port steering
    always_comb
    begin
        hdr_we     = 1'b0;
        hdr_waddr  = nxt_reg;
        hdr_wdata  = '0;
        hdr_raddr  = nxt_reg;
        mark_we    = 1'b0;
        mark_waddr = blk_reg;
        mark_wdata = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mark_we    = 1'b1;
                mark_waddr = clr_cnt_reg;
            end
            S_IDLE:
            begin
                hdr_raddr = rel_g;
            end
            S_BUILD_END:
            begin
                hdr_we    = 1'b1;
                hdr_waddr = build_end;
            end
            S_BUILD_HEAD:
            begin
                hdr_we    = 1'b1;
                hdr_waddr = '0;
                hdr_wdata = '{nxt: end_marker_reg, size: end_off};
            end
            S_A_RD:
            begin
                hdr_raddr = blk_reg;
            end
            S_A_UNLINK:
            begin
                hdr_we    = !prev_start_reg;
                hdr_waddr = prev_reg;
                hdr_wdata = '{nxt: blk_next_reg, size: prev_size_reg};
            end
            S_PB_MRG:
            begin
                hdr_we    = 1'b1;
                hdr_waddr = cur_reg;
                hdr_wdata = '{nxt: mrg_next, size: mrg_size};
            end
            S_PB_IT:
            begin
                hdr_we    = 1'b1;
                hdr_waddr = it_reg;
                hdr_wdata = '{nxt: cur_reg, size: it_size_reg};
            end
            S_FIN:
            begin
                hdr_we     = 1'b1;
                hdr_waddr  = blk_reg;
                hdr_wdata  = '{nxt: '0, size: fsize_reg};
                mark_we    = 1'b1;
                mark_wdata = 1'b1;
            end
            S_REL_CHK:
            begin
                mark_we    = mark_rd;
                mark_waddr = b_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == ffca_pkg::gidx_t'(ffca_pkg::GRANULES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_item.op == ffca_pkg::OP_ALLOC)
                    begin
                        state_next = list_ready_reg ? S_A_REQ : S_BUILD_END;
                    end
                    else if (rel_null || rel_bad)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_REL_CHK;
                    end
                end
            end
            S_BUILD_END:  state_next = S_BUILD_HEAD;
            S_BUILD_HEAD: state_next = S_A_REQ;
            S_A_REQ:
            begin
                state_next = (pre_fail_reg || (w_reg > bytes_free_reg)) ? S_RESP : S_A_RD;
            end
            S_A_RD:
            begin
                state_next = (blk_reg == end_marker_reg) ? S_RESP : S_A_CHK;
            end
            S_A_CHK:
            begin
                state_next = (hdr_rd.size >= w_reg) ? S_A_UNLINK : S_A_RD;
            end
            S_A_UNLINK:   state_next = split ? S_PB_RD : S_FIN;
            S_PB_RD:      state_next = S_PB_CHK;
            S_PB_CHK:
            begin
                state_next = (nxt_reg < b_reg) ? S_PB_RD : S_PB_CUR;
            end
            S_PB_CUR:     state_next = S_PB_MRG;
            S_PB_MRG:
            begin
                if (!at_start_reg && !left_reg)
                begin
                    state_next = S_PB_IT;
                end
                else
                begin
                    state_next = is_rel_reg ? S_RESP : S_FIN;
                end
            end
            S_PB_IT:      state_next = is_rel_reg ? S_RESP : S_FIN;
            S_FIN:        state_next = S_RESP;
            S_REL_CHK:    state_next = mark_rd ? S_PB_RD : S_RESP;
            S_RESP:
            begin
                if (resp_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            heap_size_reg   <= ffca_pkg::nbytes_t'(ffca_pkg::HEAP_SIZE_RESET);
            list_ready_reg  <= 1'b0;
            list_head_reg   <= '0;
            end_marker_reg  <= '0;
            bytes_free_reg  <= '0;
            lowest_free_reg <= '0;
            alloc_cnt_reg   <= '0;
            free_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                heap_size_reg <= cfg_wr_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ffca_pkg::gidx_t'(1);
                end
                S_BUILD_END:
                begin
                    end_marker_reg <= build_end;
                end
                S_BUILD_HEAD:
                begin
                    list_head_reg   <= '0;
                    bytes_free_reg  <= end_off;
                    lowest_free_reg <= end_off;
                    list_ready_reg  <= 1'b1;
                end
                S_A_UNLINK:
                begin
                    if (prev_start_reg)
                    begin
                        list_head_reg <= blk_next_reg;
                    end
                end
                S_PB_MRG:
                begin
                    if (at_start_reg)
                    begin
                        list_head_reg <= cur_reg;
                    end
                end
                S_FIN:
                begin
                    bytes_free_reg <= fin_free;
                    if (fin_free < lowest_free_reg)
                    begin
                        lowest_free_reg <= fin_free;
                    end
                    alloc_cnt_reg <= alloc_cnt_reg + 1'b1;
                end
                S_REL_CHK:
                begin
                    if (mark_rd)
                    begin
                        bytes_free_reg <= bytes_free_reg + hdr_rd.size;
                        free_cnt_reg   <= free_cnt_reg + 1'b1;
                    end
                end
                S_RESP:
                begin
                    if (resp_go)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    is_rel_reg   <= (in_item.op == ffca_pkg::OP_RELEASE);
                    pre_fail_reg <= req_fail;
                    w_reg        <= padded[ffca_pkg::BYTE_W-1:0];
                    b_reg        <= rel_g;
                    status_reg   <= rel_null ? ffca_pkg::ST_REL_NULL : ffca_pkg::ST_REL_REJECT;
                    addr_reg     <= '0;
                end
            end
            S_A_REQ:
            begin
                status_reg     <= ffca_pkg::ST_ALLOC_FAIL;
                blk_reg        <= list_head_reg;
                prev_start_reg <= 1'b1;
            end
            S_A_CHK:
            begin
                if (hdr_rd.size >= w_reg)
                begin
                    blk_next_reg <= hdr_rd.nxt;
                    blk_size_reg <= hdr_rd.size;
                end
                else
                begin
                    prev_reg       <= blk_reg;
                    prev_size_reg  <= hdr_rd.size;
                    prev_start_reg <= 1'b0;
                    blk_reg        <= hdr_rd.nxt;
                end
            end
            S_A_UNLINK:
            begin
                // tail of the split block starts right after the part handed out
                b_reg        <= blk_reg + w_reg[ffca_pkg::GIDX_W+2:3];
                b_size_reg   <= rem;
                fsize_reg    <= split ? w_reg : blk_size_reg;
                nxt_reg      <= prev_start_reg ? blk_next_reg : list_head_reg;
                at_start_reg <= 1'b1;
            end
            S_REL_CHK:
            begin
                b_size_reg   <= hdr_rd.size;
                nxt_reg      <= list_head_reg;
                at_start_reg <= 1'b1;
                status_reg   <= mark_rd ? ffca_pkg::ST_DONE : ffca_pkg::ST_REL_REJECT;
            end
            S_PB_CHK:
            begin
                if (nxt_reg < b_reg)
                begin
                    it_reg       <= nxt_reg;
                    it_size_reg  <= hdr_rd.size;
                    nxt_reg      <= hdr_rd.nxt;
                    at_start_reg <= 1'b0;
                end
                else
                begin
                    nxt_hdr_reg <= hdr_rd;
                end
            end
            S_PB_CUR:
            begin
                left_reg     <= left;
                cur_reg      <= left ? it_reg : b_reg;
                cur_size_reg <= left ? it_size_reg + b_size_reg : b_size_reg;
            end
            S_FIN:
            begin
                status_reg <= ffca_pkg::ST_DONE;
                addr_reg   <= {blk_reg, 3'b000} + ffca_pkg::ADDR_W'(ffca_pkg::HDR_BYTES);
            end
            S_RESP:
            begin
                if (resp_go)
                begin
                    out_item_reg <= '{status:         status_reg,
                                      address:        addr_reg,
                                      free_bytes:     bytes_free_reg,
                                      min_free_bytes: lowest_free_reg,
                                      alloc_count:    alloc_cnt_reg,
                                      free_count:     free_cnt_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    ffca_ram #(
        .WIDTH (ffca_pkg::HDR_W),
        .DEPTH (ffca_pkg::GRANULES)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (hdr_we),
        .wr_addr (hdr_waddr),
        .wr_data (hdr_wdata),
        .rd_addr (hdr_raddr),
        .rd_data (hdr_rd)
    );

    ffca_ram #(
        .WIDTH (1),
        .DEPTH (ffca_pkg::GRANULES)
    ) u_mark_ram (
        .clk     (clk),
        .wr_en   (mark_we),
        .wr_addr (mark_waddr),
        .wr_data (mark_wdata),
        .rd_addr (rel_g),
        .rd_data (mark_rd)
    );

    a_lowest_le_free: assert property (@(posedge clk) disable iff (!rst_n)
        lowest_free_reg <= bytes_free_reg)
        else $error("lowest free count above current free count");

    a_free_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        list_ready_reg |-> (bytes_free_reg <= {1'b0, end_marker_reg, 3'b000}))
        else $error("free bytes exceed heap span");

    a_unbuilt_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !list_ready_reg |-> (bytes_free_reg == '0))
        else $error("free bytes nonzero before the list is built");

    a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_item_reg.address != '0)) |->
        ((out_item_reg.status == ffca_pkg::ST_DONE) && (out_item_reg.address[2:0] == 3'd0)))
        else $error("address given on a failed item or misaligned");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("item taken during mark clearing");

endmodule
`default_nettype wire
